>>> sv/assert_macros.svh
// Assertion macros used by the component counter controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bicc_pkg.sv
// Types and constants for the binary image component counter.
// No dependencies.
package bicc_pkg;

    localparam int CountW    = 12;
    localparam int RowWidthW = 7;
    localparam logic [RowWidthW-1:0] RowWidthReset = 7'd64;

    typedef struct packed {
        logic pixel_set;
        logic frame_end;
    } t_in_item;

    typedef struct packed {
        logic [CountW-1:0] component_count;
        logic              overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CFG,
        OP_ACCEPT,
        OP_FIND_START,
        OP_FIND_STEP,
        OP_FIND_DONE,
        OP_CMP_READ,
        OP_CMP_STEP,
        OP_UNION,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_up;
    } t_cmd;

    typedef struct packed {
        logic do_left;
        logic do_up;
        logic rd_is_self;
        logic rd_is_root;
        logic cur_is_root;
        logic out_busy;
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FIND,
        S_CMP0,
        S_CMP,
        S_UNION,
        S_EMIT
    } t_state;

endpackage

>>> sv/bicc_datapath.sv
// Datapath: parent table memory, frame bookkeeping, count and result register.
// Depends on bicc_pkg.
module bicc_datapath #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_PIXELS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bicc_pkg::t_cmd                      i_cmd,
    output bicc_pkg::t_status                   o_status,
    input  bicc_pkg::t_in_item                  i_in_item,
    input  logic [bicc_pkg::RowWidthW-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bicc_pkg::t_out_item                 o_out_item
);
    import bicc_pkg::*;

    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int IW = $clog2(MAX_PIXELS + 1);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WW = $clog2(MAX_COLS + 1);

    logic [PW-1:0]        r_mem [MAX_PIXELS];
    logic [PW-1:0]        r_rdata;
    logic [RowWidthW-1:0] r_row_width;
    logic [MAX_COLS-1:0]  r_prev_row;
    logic                 r_left;
    logic [CW-1:0]        r_col;
    logic [IW-1:0]        r_pix_idx;
    logic [CountW-1:0]    r_count;
    logic                 r_ovf;
    logic [PW-1:0]        r_p;
    logic [PW-1:0]        r_cur;
    logic [PW-1:0]        r_root;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [WW-1:0] w;
    logic          in_range;
    logic          pix;
    logic [PW-1:0] node;
    logic [PW-1:0] raddr;
    logic          we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] wdata;
    logic          col_wrap;

    always_comb begin
        if (r_row_width == '0) begin
            w = WW'(1);
        end else if (32'(r_row_width) > MAX_COLS) begin
            w = WW'(MAX_COLS);
        end else begin
            w = WW'(r_row_width);
        end
    end

    assign pix      = i_in_item.pixel_set;
    assign in_range = 32'(r_pix_idx) < MAX_PIXELS;
    assign col_wrap = (32'(r_col) + 32'd1) >= 32'(w);
    assign node     = i_cmd.sel_up ? PW'(32'(r_p) - 32'(w)) : (r_p - PW'(1));

    // The upper bit is only used once a full row of the frame has passed, so the
    // row buffer needs no clearing between frames.
    assign o_status.do_left     = pix && in_range && r_left && (r_col != '0)
                                  && (r_pix_idx != '0);
    assign o_status.do_up       = pix && in_range && r_prev_row[r_col]
                                  && (32'(r_pix_idx) >= 32'(w));
    assign o_status.rd_is_self  = r_rdata == r_cur;
    assign o_status.rd_is_root  = r_rdata == r_root;
    assign o_status.cur_is_root = r_cur == r_root;
    assign o_status.out_busy    = r_out_valid && !i_out_ready;

    always_comb begin
        raddr = r_cur;
        we    = 1'b0;
        waddr = r_cur;
        wdata = r_root;
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                we    = pix && in_range;
                waddr = r_pix_idx[PW-1:0];
                wdata = r_pix_idx[PW-1:0];
            end
            OP_FIND_START: raddr = node;
            OP_FIND_STEP:  raddr = r_rdata;
            OP_CMP_READ:   raddr = r_cur;
            OP_CMP_STEP: begin
                raddr = r_rdata;
                we    = 1'b1;
                waddr = r_cur;
                wdata = r_root;
            end
            OP_UNION: begin
                we    = r_root != r_p;
                waddr = r_root;
                wdata = r_p;
            end
            default: raddr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_ACCEPT:     r_p <= r_pix_idx[PW-1:0];
            OP_FIND_START: r_cur <= node;
            OP_FIND_STEP:  r_cur <= r_rdata;
            OP_FIND_DONE: begin
                r_root <= r_cur;
                r_cur  <= node;
            end
            OP_CMP_STEP:   r_cur <= r_rdata;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RowWidthReset;
            r_prev_row  <= '0;
            r_left      <= 1'b0;
            r_col       <= '0;
            r_pix_idx   <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_CFG, OP_EMIT: begin
                    if (i_cmd.op == OP_CFG) begin
                        r_row_width <= i_cfg_data;
                    end else begin
                        r_out_valid           <= 1'b1;
                        r_out.component_count <= r_count;
                        r_out.overflow        <= r_ovf;
                    end
                    r_left     <= 1'b0;
                    r_col      <= '0;
                    r_pix_idx  <= '0;
                    r_count    <= '0;
                    r_ovf      <= 1'b0;
                end
                OP_ACCEPT: begin
                    if (!in_range) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_prev_row[r_col] <= pix;
                        r_pix_idx         <= r_pix_idx + IW'(1);
                        if (col_wrap) begin
                            r_col  <= '0;
                            r_left <= 1'b0;
                        end else begin
                            r_col  <= r_col + CW'(1);
                            r_left <= pix;
                        end
                        if (pix) begin
                            r_count <= r_count + CountW'(1);
                        end
                    end
                end
                OP_UNION: begin
                    if (r_root != r_p) begin
                        r_count <= r_count - CountW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> sv/bicc_controller.sv
// Controller state machine sequencing finds, path compression and unions.
// Depends on bicc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bicc_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_frame_end,
    output logic              o_in_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  bicc_pkg::t_status i_status,
    output bicc_pkg::t_cmd    o_cmd
);
    import bicc_pkg::*;

    t_state r_state, n_state;
    logic   r_do_up, n_do_up;
    logic   r_last, n_last;
    logic   r_phase_up, n_phase_up;
    logic   in_acc;

    assign o_cfg_ready = r_state == S_IDLE;
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid
                         && !(i_frame_end && i_status.out_busy);
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_do_up    <= 1'b0;
            r_last     <= 1'b0;
            r_phase_up <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_do_up    <= n_do_up;
            r_last     <= n_last;
            r_phase_up <= n_phase_up;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_do_up      = r_do_up;
        n_last       = r_last;
        n_phase_up   = r_phase_up;
        o_cmd.op     = OP_NONE;
        o_cmd.sel_up = r_phase_up;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.op = OP_CFG;
                end else if (in_acc) begin
                    o_cmd.op = OP_ACCEPT;
                    n_do_up  = i_status.do_up;
                    n_last   = i_frame_end;
                    if (i_status.do_left) begin
                        n_phase_up = 1'b0;
                        n_state    = S_START;
                    end else if (i_status.do_up) begin
                        n_phase_up = 1'b1;
                        n_state    = S_START;
                    end else if (i_frame_end) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_START: begin
                o_cmd.op = OP_FIND_START;
                n_state  = S_FIND;
            end
            S_FIND: begin
                if (i_status.rd_is_self) begin
                    o_cmd.op = OP_FIND_DONE;
                    n_state  = S_CMP0;
                end else begin
                    o_cmd.op = OP_FIND_STEP;
                end
            end
            S_CMP0: begin
                if (i_status.cur_is_root) begin
                    n_state = S_UNION;
                end else begin
                    o_cmd.op = OP_CMP_READ;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.op = OP_CMP_STEP;
                if (i_status.rd_is_root) begin
                    n_state = S_UNION;
                end
            end
            S_UNION: begin
                o_cmd.op = OP_UNION;
                if (!r_phase_up && r_do_up) begin
                    n_phase_up = 1'b1;
                    n_state    = S_START;
                end else if (r_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == S_IDLE, "not idle after reset")
    `ASSERT_RST(a_emit_idle, i_clk, i_rst_n, r_state == S_EMIT |=> r_state == S_IDLE, "emit stuck")
    `ASSERT_RST(a_walk, i_clk, i_rst_n, (r_state == S_FIND && !i_status.rd_is_self) |=> r_state == S_FIND, "walk left early")
    `ASSERT_RST(a_union_from, i_clk, i_rst_n, r_state == S_UNION |-> ($past(r_state) == S_CMP || $past(r_state) == S_CMP0), "union without find")

endmodule

>>> sv/binary_image_component_counter.sv
// Binary image component counter: 4-connected foreground components by union-find.
// Items are taken one at a time: a pixel with a set left or upper neighbour holds off
// input while each union (at most two per pixel) runs its find, path compression and union.
// The count item is registered in the emit state after the last pixel's work ends; a last pixel
// waits while an earlier count item is still unaccepted.
// Synchronous active-low reset clears all frame state; the parent table is not cleared.
module binary_image_component_counter #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_PIXELS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bicc_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bicc_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bicc_pkg::RowWidthW-1:0] i_cfg_data
);
    import bicc_pkg::*;

    t_cmd    cmd;
    t_status status;

    bicc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_in_item.frame_end),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bicc_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
